// ----- rtl/core/dmcb_pkg.sv -----
`default_nettype none

package dmcb_pkg;

  // Cache geometry
  localparam int unsigned NUM_LINES   = 128;
  localparam int unsigned BLOCK_BYTES = 32;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned OFF_W  = $clog2(BLOCK_BYTES);
  localparam int unsigned LINE_W = $clog2(NUM_LINES);
  localparam int unsigned BLK_W  = ADDR_W - OFF_W;
  localparam int unsigned TAG_W  = BLK_W - LINE_W;
  localparam int unsigned CNT_W  = 32;

  // Tag RAM entry: dirty bit above the tag
  localparam int unsigned ENTRY_W = TAG_W + 1;

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              func;
  } in_t;

  typedef struct packed {
    logic [OFF_W-1:0]  byte_offset;
    logic [BLK_W-1:0]  block_number;
    logic [LINE_W-1:0] line_index;
    logic [TAG_W-1:0]  tag_value;
    logic              miss;
    logic              mem_read;
    logic              mem_write;
    logic              replacement;
    logic [TAG_W-1:0]  victim_tag;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/core/direct_mapped_copy_back_cache_top.sv -----
// Direct-mapped copy-back cache tag controller.
//
// Input channel: a reference (byte address, read/write) is transferred on a
// rising edge where start is high and busy is low. busy rises the cycle after
// a transfer and stays high for one cycle while the tag lookup runs.
//
// Result channel: out_strobe is high for exactly one cycle with out_item
// holding the split address, hit/miss, block fetch, dirty write-back,
// replacement, victim tag and the running hit and miss counts. The receiver
// must take the result in that cycle; it has no way to stall the block.
//
// Sequence: the tag RAM line is read on the transfer edge, then compared and
// written back in the lookup state (ST_LOOK), where the result is registered.
// A new reference is not accepted while this lookup runs.
// The next reference may be transferred in the cycle the result is shown.
//
// Reset (rst_n low, synchronous): all lines become invalid and clean, both
// counters clear, no result is pending. The tag RAM is not cleared; a tag is
// only used while its line is valid.
`default_nettype none

module direct_mapped_copy_back_cache_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire dmcb_pkg::in_t in_item,
  output logic               out_strobe,
  output dmcb_pkg::out_t     out_item
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t state_r;

  // Request registers, valid bits, counters and result registers
  logic [dmcb_pkg::ADDR_W-1:0]    addr_r;
  logic                           func_r;
  logic [dmcb_pkg::NUM_LINES-1:0] valid_r;
  logic [dmcb_pkg::CNT_W-1:0]     hits_r;
  logic [dmcb_pkg::CNT_W-1:0]     misses_r;
  logic                           out_strobe_r;
  dmcb_pkg::out_t                 out_item_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r == ST_LOOK);

  // Address split of the held request
  logic [dmcb_pkg::OFF_W-1:0]  off;
  logic [dmcb_pkg::BLK_W-1:0]  blk;
  logic [dmcb_pkg::LINE_W-1:0] line;
  logic [dmcb_pkg::TAG_W-1:0]  tag;
  assign off  = addr_r[dmcb_pkg::OFF_W-1:0];
  assign blk  = addr_r[dmcb_pkg::ADDR_W-1:dmcb_pkg::OFF_W];
  assign line = addr_r[dmcb_pkg::OFF_W +: dmcb_pkg::LINE_W];
  assign tag  = addr_r[dmcb_pkg::ADDR_W-1 -: dmcb_pkg::TAG_W];

  // Tag RAM: read on transfer, written back in the lookup cycle
  logic [dmcb_pkg::ENTRY_W-1:0] rd_entry;
  logic [dmcb_pkg::ENTRY_W-1:0] wr_entry;
  logic                         ram_we;

  dmcb_ram #(
    .WIDTH (dmcb_pkg::ENTRY_W),
    .DEPTH (dmcb_pkg::NUM_LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line),
    .wdata (wr_entry),
    .re    (accept),
    .raddr (in_item.address[dmcb_pkg::OFF_W +: dmcb_pkg::LINE_W]),
    .rdata (rd_entry)
  );

  // Lookup
  logic                        line_valid;
  logic                        old_dirty;
  logic [dmcb_pkg::TAG_W-1:0]  old_tag;
  logic                        hit;
  logic                        wr;
  logic                        dirty_nxt;
  logic [dmcb_pkg::CNT_W-1:0]  hits_nxt;
  logic [dmcb_pkg::CNT_W-1:0]  misses_nxt;
  dmcb_pkg::out_t              out_item_nxt;

  always_comb begin
    line_valid = valid_r[line];
    old_dirty  = rd_entry[dmcb_pkg::TAG_W];
    old_tag    = rd_entry[dmcb_pkg::TAG_W-1:0];
    hit        = line_valid && (old_tag == tag);
    wr         = (func_r == dmcb_pkg::FUNC_WRITE);
    // write hit sets dirty; miss loads dirty from the access kind
    dirty_nxt  = hit ? (old_dirty || wr) : wr;
    wr_entry   = {dirty_nxt, tag};
    ram_we     = (state_r == ST_LOOK);
    hits_nxt   = hit ? hits_r + dmcb_pkg::CNT_W'(1) : hits_r;
    misses_nxt = hit ? misses_r : misses_r + dmcb_pkg::CNT_W'(1);

    out_item_nxt.byte_offset  = off;
    out_item_nxt.block_number = blk;
    out_item_nxt.line_index   = line;
    out_item_nxt.tag_value    = tag;
    out_item_nxt.miss         = !hit;
    out_item_nxt.mem_read     = !hit;
    out_item_nxt.mem_write    = !hit && line_valid && old_dirty;
    out_item_nxt.replacement  = !hit && line_valid;
    out_item_nxt.victim_tag   = (!hit && line_valid) ? old_tag : '0;
    out_item_nxt.hit_count    = hits_nxt;
    out_item_nxt.miss_count   = misses_nxt;
  end

  // State, valid bits, counters and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          valid_r[line] <= 1'b1;
          hits_r        <= hits_nxt;
          misses_r      <= misses_nxt;
          out_strobe_r  <= 1'b1;
          state_r       <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_item.address;
      func_r <= in_item.func;
    end
    if (state_r == ST_LOOK) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

// ----- rtl/core/dmcb_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one read port, registered read data
module dmcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dmcb_checker.sv -----
`default_nettype none

module dmcb_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           out_strobe,
  input wire dmcb_pkg::out_t out_item
);

  // A transfer raises busy
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  // Every transfer is followed by its result strobe once the lookup state is over
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> ##1 out_strobe)
    else $error("result missing two cycles after transfer");

  // A hit causes no memory traffic and no eviction
  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.miss) |->
      (!out_item.mem_read && !out_item.mem_write && !out_item.replacement))
    else $error("memory traffic reported on a hit");

  // Write-back and a victim tag only come with a replacement
  a_victim_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.replacement) |->
      (!out_item.mem_write && out_item.victim_tag == '0))
    else $error("write-back or victim tag without replacement");

  // Back-to-back results raise the sum of the hit and miss counts by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(out_strobe, 2) && $past(rst_n, 2)) |->
      ((out_item.hit_count + out_item.miss_count) ==
       ($past(out_item.hit_count, 2) + $past(out_item.miss_count, 2) + 32'd1)))
    else $error("hit/miss counters did not advance by one");

endmodule

bind direct_mapped_copy_back_cache_top dmcb_checker u_dmcb_checker (.*);

`default_nettype wire
